// ===== sv/nce_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nce_pkg: shared types and constants of the neighbour cell enumerator
// Grid limits, field widths, offset codes, register map and the record
// that passes from the front end to the back end through the queue.
// ---------------------------------------------------------------------------
package nce_pkg;

  localparam int MAX_CELLS_PER_AXIS = 64;

  // Field widths fixed by the interface.
  localparam int CFG_W  = 7;
  localparam int CELL_W = 18;
  localparam int CNT_W  = 5;

  // Widths that follow from the grid limit.
  localparam int AXIS_W  = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int COORD_W = $clog2(MAX_CELLS_PER_AXIS);
  localparam int PLANE_W = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);
  localparam int VOL_W   = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS
                                  * MAX_CELLS_PER_AXIS + 1);

  // Divider: bits of quotient retired per cycle and cycles per division.
  localparam int DIV_BITS  = 3;
  localparam int DIV_STEPS = (CELL_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = AXIS_W;

  // Queue between front and back end.
  localparam int QDEPTH = 2;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_CELLS_X     = 2'd0;
  localparam logic [1:0] REG_CELLS_Y     = 2'd1;
  localparam logic [1:0] REG_CELLS_Z     = 2'd2;
  localparam logic [1:0] REG_WRAP_ENABLE = 2'd3;

  // Offset codes along one axis.
  typedef logic [1:0] off_t;
  localparam off_t OFF_NEG  = 2'd0;
  localparam off_t OFF_ZERO = 2'd1;
  localparam off_t OFF_POS  = 2'd2;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIVX,
    F_DIVY,
    F_DIVZ,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_t;

  // One classified request: the partial linear index of each axis for each
  // offset, the range of offsets to visit on each axis, and the result count.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] xt;
    logic [2:0][CELL_W-1:0]  yt;
    logic [2:0][CELL_W-1:0]  zt;
    off_t [2:0]              ostart;
    off_t [2:0]              oend;
    logic [CNT_W-1:0]        total;
  } entry_t;

  // Clamp a raw axis size into the supported range.
  function automatic logic [AXIS_W-1:0] sat_axis(input logic [CFG_W-1:0] v);
    logic [AXIS_W-1:0] r;
    if (v == '0) r = AXIS_W'(1);
    else if (v > CFG_W'(MAX_CELLS_PER_AXIS)) r = AXIS_W'(MAX_CELLS_PER_AXIS);
    else r = AXIS_W'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/neighbor_cell_enumerator_3d.sv =====
`default_nettype none
// Neighbour cell enumerator for a 3-D cell grid. Each request carries a
// linear cell index; the block answers with the indices of the cells at
// offsets -1..+1 on each axis (x outermost, z innermost, centre included),
// one result per cycle while the receiver does not stall, the last result
// marked and carrying the count. With wrap_enable set, off-grid neighbours
// wrap round the grid; with it clear they are skipped; a single-cell grid
// gives the centre alone. The back end delivers one result per cycle while
// out_stall is low. The front end classifies a request by three serial
// divisions through one shared divider retiring three quotient bits a
// cycle, two multiply stages and a queue write that waits while the queue
// is full. A new request is taken while the last is still in progress, and
// a two-entry queue plus a holding register keep both ends busy. The grid
// size registers must only be written while no request is in flight.
// ---------------------------------------------------------------------------
// neighbor_cell_enumerator_3d: top level
// Configuration registers, front end, request queue and back end.
// ---------------------------------------------------------------------------
module neighbor_cell_enumerator_3d (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nce_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [nce_pkg::DATA_W-1:0]  pwdata,
  output logic      [nce_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [nce_pkg::CELL_W-1:0]  cell_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [nce_pkg::CELL_W-1:0]  neighbor_cell,
  output logic      [nce_pkg::CNT_W-1:0]   position,
  output logic                             final_res,
  output logic      [nce_pkg::CNT_W-1:0]   total
);
  import nce_pkg::*;

  logic [CFG_W-1:0] cells_x, cells_y, cells_z;
  logic             wrap_enable;
  logic             wr_en;

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_wdata, q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x     <= CFG_W'(1);
      cells_y     <= CFG_W'(1);
      cells_z     <= CFG_W'(1);
      wrap_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CELLS_X:     cells_x     <= pwdata[CFG_W-1:0];
        REG_CELLS_Y:     cells_y     <= pwdata[CFG_W-1:0];
        REG_CELLS_Z:     cells_z     <= pwdata[CFG_W-1:0];
        REG_WRAP_ENABLE: wrap_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CELLS_X:     prdata = DATA_W'(cells_x);
      REG_CELLS_Y:     prdata = DATA_W'(cells_y);
      REG_CELLS_Z:     prdata = DATA_W'(cells_z);
      REG_WRAP_ENABLE: prdata = DATA_W'(wrap_enable);
      default:         prdata = '0;
    endcase
  end

  nce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cell_index  (cell_index),
    .cells_x     (cells_x),
    .cells_y     (cells_y),
    .cells_z     (cells_z),
    .wrap_enable (wrap_enable),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  nce_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  nce_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .neighbor_cell (neighbor_cell),
    .position      (position),
    .final_res     (final_res),
    .total         (total)
  );

endmodule
`default_nettype wire

// ===== sv/nce_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nce_div: iterative unsigned divider
// Restoring division of an index by an axis size, several quotient bits per
// cycle; quotient and remainder stay valid from done until the next start.
// ---------------------------------------------------------------------------
module nce_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [nce_pkg::CELL_W-1:0] dividend,
  input  wire logic [nce_pkg::AXIS_W-1:0] divisor,
  output logic                            done,
  output logic [nce_pkg::CELL_W-1:0]      quot,
  output logic [nce_pkg::COORD_W-1:0]     rem_out
);
  import nce_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CELL_W-1:0]    acc;
  logic [REM_W-1:0]     rem;
  logic [AXIS_W-1:0]    dvs;
  logic [CELL_W-1:0]    acc_next;
  logic [REM_W-1:0]     rem_next;

  always_comb begin
    acc_next = acc;
    rem_next = rem;
    for (int s = 0; s < DIV_BITS; s++) begin
      rem_next = {rem_next[REM_W-2:0], acc_next[CELL_W-1]};
      acc_next = {acc_next[CELL_W-2:0], 1'b0};
      if (rem_next >= REM_W'(dvs)) begin
        rem_next    = rem_next - REM_W'(dvs);
        acc_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quot    = acc;
  assign rem_out = COORD_W'(rem);

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < REM_W'(dvs)))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// ===== sv/nce_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nce_front: request intake and classification
// Splits a linear index into grid coordinates, works out the partial index
// terms for every offset and the offset range per axis, and queues them.
// ---------------------------------------------------------------------------
module nce_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [nce_pkg::CELL_W-1:0] cell_index,
  input  wire logic [nce_pkg::CFG_W-1:0]  cells_x,
  input  wire logic [nce_pkg::CFG_W-1:0]  cells_y,
  input  wire logic [nce_pkg::CFG_W-1:0]  cells_z,
  input  wire logic                       wrap_enable,
  input  wire logic                       q_full,
  output logic                            q_push,
  output nce_pkg::entry_t                 q_wdata
);
  import nce_pkg::*;

  front_state_t state, state_next;

  logic              hold_valid;
  logic              hold_take;
  logic [CELL_W-1:0] hold_index;

  logic              div_start;
  logic              div_done;
  logic [CELL_W-1:0] div_dividend;
  logic [AXIS_W-1:0] div_divisor;
  logic [CELL_W-1:0] div_quot;
  logic [COORD_W-1:0] div_rem;

  logic [AXIS_W-1:0]  n0, n1, n2;
  logic [AXIS_W-1:0]  n0m1, n1m1, n2m1;
  logic               single;
  logic [COORD_W-1:0] x, y, z;
  logic [PLANE_W-1:0] n01;
  logic [PLANE_W-1:0] y0n;
  logic [CELL_W-1:0]  z0n;
  logic [VOL_W-1:0]   nall;

  logic               lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [1:0]         cnt_x, cnt_y, cnt_z;

  assign n0     = sat_axis(cells_x);
  assign n1     = sat_axis(cells_y);
  assign n2     = sat_axis(cells_z);
  assign n0m1   = n0 - 1'b1;
  assign n1m1   = n1 - 1'b1;
  assign n2m1   = n2 - 1'b1;
  assign single = (n0 == AXIS_W'(1)) && (n1 == AXIS_W'(1)) && (n2 == AXIS_W'(1));

  // A one-deep holding register takes the next request while the current
  // one is still being decomposed.
  assign in_stall = hold_valid;

  nce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem_out  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      hold_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && !hold_valid) hold_valid <= 1'b1;
      else if (hold_take) hold_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = hold_index;
    div_divisor  = n0;
    q_push       = 1'b0;
    hold_take    = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (hold_valid) begin
          div_start  = 1'b1;
          hold_take  = 1'b1;
          state_next = F_DIVX;
        end
      end
      F_DIVX: begin
        div_dividend = div_quot;
        div_divisor  = n1;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = F_DIVY;
        end
      end
      F_DIVY: begin
        div_dividend = div_quot;
        div_divisor  = n2;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = F_DIVZ;
        end
      end
      F_DIVZ: begin
        if (div_done) state_next = F_MUL1;
      end
      F_MUL1: state_next = F_MUL2;
      F_MUL2: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold_valid) hold_index <= cell_index;
    if (div_done && state == F_DIVX) x <= div_rem;
    if (div_done && state == F_DIVY) y <= div_rem;
    if (div_done && state == F_DIVZ) z <= div_rem;
    if (state == F_MUL1) begin
      n01 <= PLANE_W'(PLANE_W'(n0) * PLANE_W'(n1));
      y0n <= PLANE_W'(PLANE_W'(y) * PLANE_W'(n0));
    end
    if (state == F_MUL2) begin
      z0n  <= CELL_W'(CELL_W'(z) * CELL_W'(n01));
      nall <= VOL_W'(VOL_W'(n2) * VOL_W'(n01));
    end
  end

  // Offsets that leave the grid are visited only with wrap enabled; a
  // single-cell grid visits the centre alone.
  assign lo_x  = !single && (wrap_enable || x != '0);
  assign hi_x  = !single && (wrap_enable || AXIS_W'(x) != n0m1);
  assign lo_y  = !single && (wrap_enable || y != '0);
  assign hi_y  = !single && (wrap_enable || AXIS_W'(y) != n1m1);
  assign lo_z  = !single && (wrap_enable || z != '0);
  assign hi_z  = !single && (wrap_enable || AXIS_W'(z) != n2m1);
  assign cnt_x = 2'd1 + {1'b0, lo_x} + {1'b0, hi_x};
  assign cnt_y = 2'd1 + {1'b0, lo_y} + {1'b0, hi_y};
  assign cnt_z = 2'd1 + {1'b0, lo_z} + {1'b0, hi_z};

  always_comb begin
    q_wdata = '0;

    q_wdata.xt[OFF_NEG]  = (x == '0) ? COORD_W'(n0m1) : x - 1'b1;
    q_wdata.xt[OFF_ZERO] = x;
    q_wdata.xt[OFF_POS]  = (AXIS_W'(x) == n0m1) ? '0 : x + 1'b1;

    q_wdata.yt[OFF_NEG]  = (y == '0) ? CELL_W'(n01) - CELL_W'(n0)
                                     : CELL_W'(y0n) - CELL_W'(n0);
    q_wdata.yt[OFF_ZERO] = CELL_W'(y0n);
    q_wdata.yt[OFF_POS]  = (AXIS_W'(y) == n1m1) ? '0 : CELL_W'(y0n) + CELL_W'(n0);

    q_wdata.zt[OFF_NEG]  = (z == '0) ? CELL_W'(nall - VOL_W'(n01))
                                     : z0n - CELL_W'(n01);
    q_wdata.zt[OFF_ZERO] = z0n;
    q_wdata.zt[OFF_POS]  = (AXIS_W'(z) == n2m1) ? '0 : z0n + CELL_W'(n01);

    q_wdata.ostart[0] = lo_x ? OFF_NEG : OFF_ZERO;
    q_wdata.ostart[1] = lo_y ? OFF_NEG : OFF_ZERO;
    q_wdata.ostart[2] = lo_z ? OFF_NEG : OFF_ZERO;
    q_wdata.oend[0]   = hi_x ? OFF_POS : OFF_ZERO;
    q_wdata.oend[1]   = hi_y ? OFF_POS : OFF_ZERO;
    q_wdata.oend[2]   = hi_z ? OFF_POS : OFF_ZERO;

    q_wdata.total = CNT_W'(CNT_W'(cnt_x) * CNT_W'(cnt_y) * CNT_W'(cnt_z));
  end

endmodule
`default_nettype wire

// ===== sv/nce_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nce_queue: short request queue
// Holds classified requests between the front end and the back end so that
// each side can stall on its own.
// ---------------------------------------------------------------------------
module nce_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire nce_pkg::entry_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output nce_pkg::entry_t      head,
  output logic                 empty
);
  import nce_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_Q = $clog2(QDEPTH + 1);

  entry_t             mem [QDEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_Q-1:0]   count;

  assign full  = (count == CNT_Q'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("request queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("request queue read while empty");

endmodule
`default_nettype wire

// ===== sv/nce_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// nce_back: neighbour emission
// Walks the offset ranges of the request at the head of the queue, x
// outermost, z innermost, and emits one neighbour index per cycle unless stalled.
// ---------------------------------------------------------------------------
module nce_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nce_pkg::entry_t             head,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [nce_pkg::CELL_W-1:0]       neighbor_cell,
  output logic [nce_pkg::CNT_W-1:0]        position,
  output logic                             final_res,
  output logic [nce_pkg::CNT_W-1:0]        total
);
  import nce_pkg::*;

  logic             active;
  off_t             i, j, k;
  logic [CNT_W-1:0] pos;

  off_t             cur_i, cur_j, cur_k;
  off_t             i_next, j_next, k_next;
  logic [CNT_W-1:0] cur_pos;
  logic             last;
  logic             emit;

  // At the start of a request the walk begins at the range start directly,
  // so the walk of a request follows straight on from the one before.
  assign cur_i   = active ? i : head.ostart[0];
  assign cur_j   = active ? j : head.ostart[1];
  assign cur_k   = active ? k : head.ostart[2];
  assign cur_pos = active ? pos : '0;

  assign last = (cur_i == head.oend[0]) && (cur_j == head.oend[1]) &&
                (cur_k == head.oend[2]);
  assign emit  = !q_empty && (!out_valid || !out_stall);
  assign q_pop = emit && last;

  always_comb begin
    i_next = cur_i;
    j_next = cur_j;
    k_next = cur_k;
    if (cur_k != head.oend[2]) begin
      k_next = cur_k + 1'b1;
    end else begin
      k_next = head.ostart[2];
      if (cur_j != head.oend[1]) begin
        j_next = cur_j + 1'b1;
      end else begin
        j_next = head.ostart[1];
        i_next = cur_i + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        active    <= !last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      i             <= i_next;
      j             <= j_next;
      k             <= k_next;
      pos           <= cur_pos + 1'b1;
      neighbor_cell <= CELL_W'(head.xt[cur_i]) + head.yt[cur_j] + head.zt[cur_k];
      position      <= cur_pos;
      final_res     <= last;
      total         <= last ? head.total : '0;
    end
  end

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_res) |-> (total == position + 1'b1))
    else $error("count on last result does not match its position");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !final_res) |-> (total == '0))
    else $error("count given on a result that is not the last");

endmodule
`default_nettype wire

// ===== tb/neighbor_cell_enumerator_3d_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// neighbor_cell_enumerator_3d_test: self-checking bench for the enumerator
// Drives requests and grid settings and predicts every neighbour index of
// each accepted request. Each delivered result is compared field by field
// with the oldest prediction. The run covers random idling on both channels
// and one long receiver hold-off.
// ---------------------------------------------------------------------------
module neighbor_cell_enumerator_3d_test;
  import nce_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 60;

  typedef struct {
    logic [CELL_W-1:0] nbr;
    logic [CNT_W-1:0]  pos;
    logic              is_last;
    logic [CNT_W-1:0]  cnt;
  } neighbour_t;

  // Holds the grid settings and the neighbour indices still to be delivered.
  class neighbour_tracker;
    logic [CFG_W-1:0] cfg_x, cfg_y, cfg_z;
    logic             wrap;
    neighbour_t       awaited[$];
    int               errors;

    function new();
      cfg_x  = 1;
      cfg_y  = 1;
      cfg_z  = 1;
      wrap   = 1'b1;
      errors = 0;
    endfunction

    static function int axis_cells(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
      return int'(v);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, int unsigned value);
      case (idx)
        REG_CELLS_X:     cfg_x = CFG_W'(value);
        REG_CELLS_Y:     cfg_y = CFG_W'(value);
        REG_CELLS_Z:     cfg_z = CFG_W'(value);
        REG_WRAP_ENABLE: wrap = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Works out every neighbour of an accepted request, in delivery order.
    function void note_request(logic [CELL_W-1:0] idx);
      int         n[3];
      int         c[3];
      int         d[3];
      int         q[3];
      int         p;
      int         v;
      int         count;
      bit         off;
      neighbour_t r;
      n[0] = axis_cells(cfg_x);
      n[1] = axis_cells(cfg_y);
      n[2] = axis_cells(cfg_z);
      // A single-cell grid answers with cell 0 alone.
      if (n[0] == 1 && n[1] == 1 && n[2] == 1) begin
        r.nbr = '0;
        r.pos = '0;
        r.is_last = 1'b1;
        r.cnt = CNT_W'(1);
        awaited.push_back(r);
        return;
      end
      v = int'(idx);
      c[0] = v % n[0];
      c[1] = (v / n[0]) % n[1];
      c[2] = (v / n[0] / n[1]) % n[2];
      count = 0;
      for (int di = -1; di <= 1; di++) begin
        for (int dj = -1; dj <= 1; dj++) begin
          for (int dk = -1; dk <= 1; dk++) begin
            d[0] = di;
            d[1] = dj;
            d[2] = dk;
            off = 1'b0;
            for (int a = 0; a < 3; a++) begin
              p = c[a] + d[a];
              if (p < 0) begin
                off = 1'b1;
                p += n[a];
              end else if (p >= n[a]) begin
                off = 1'b1;
                p -= n[a];
              end
              q[a] = p;
            end
            if (off && !wrap) continue;
            r.nbr = CELL_W'(q[0] + q[1] * n[0] + q[2] * n[0] * n[1]);
            r.pos = CNT_W'(count);
            r.is_last = 1'b0;
            r.cnt = '0;
            awaited.push_back(r);
            count++;
          end
        end
      end
      r = awaited[awaited.size() - 1];
      r.is_last = 1'b1;
      r.cnt = CNT_W'(count);
      awaited[awaited.size() - 1] = r;
    endfunction

    task check_result(logic [CELL_W-1:0] got_nbr, logic [CNT_W-1:0] pos,
                      logic fin, logic [CNT_W-1:0] cnt);
      neighbour_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result cell %0d position %0d", got_nbr, pos));
        return;
      end
      want = awaited.pop_front();
      if (got_nbr !== want.nbr)
        report($sformatf("neighbor_cell %0d, wanted %0d (position %0d)",
                         got_nbr, want.nbr, want.pos));
      if (pos !== want.pos)
        report($sformatf("position %0d, wanted %0d", pos, want.pos));
      if (fin !== want.is_last)
        report($sformatf("final_res %0b, wanted %0b (position %0d)",
                         fin, want.is_last, want.pos));
      if (cnt !== want.cnt)
        report($sformatf("total %0d, wanted %0d (position %0d)", cnt, want.cnt, want.pos));
    endtask
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CELL_W-1:0]   cell_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CELL_W-1:0]   neighbor_cell;
  logic [CNT_W-1:0]    position;
  logic                final_res;
  logic [CNT_W-1:0]    total;

  neighbour_tracker tracker = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int grid_x = 1;
  int grid_y = 1;
  int grid_z = 1;

  neighbor_cell_enumerator_3d u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cell_index    (cell_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .neighbor_cell (neighbor_cell),
    .position      (position),
    .final_res     (final_res),
    .total         (total)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("neighbor_cell_enumerator_3d test failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so that the block backs
  // up and stalls its request side.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && requests_sent >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_result(neighbor_cell, position, final_res, total);
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Lets every outstanding neighbour arrive before anything else changes.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned cx, input int unsigned cy,
                           input int unsigned cz, input int unsigned wr);
    drain();
    write_reg(REG_CELLS_X, cx);
    write_reg(REG_CELLS_Y, cy);
    write_reg(REG_CELLS_Z, cz);
    write_reg(REG_WRAP_ENABLE, wr);
    grid_x = neighbour_tracker::axis_cells(CFG_W'(cx));
    grid_y = neighbour_tracker::axis_cells(CFG_W'(cy));
    grid_z = neighbour_tracker::axis_cells(CFG_W'(cz));
  endtask

  task automatic send_request(input logic [CELL_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
    tracker.note_request(idx);
    requests_sent++;
  endtask

  task automatic set_idling(input int s, input int r);
    send_idle_pct = s;
    recv_idle_pct = r;
  endtask

  function automatic int unsigned boundary_coord(input int unsigned n);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Mostly indices on the grid, many of them on a face or corner, and some
  // drawn from the whole field so that the z modulo is exercised.
  function automatic logic [CELL_W-1:0] pick_index();
    int unsigned x, y, z;
    case ($urandom_range(0, 9))
      0, 1: return CELL_W'($urandom_range(0, 2**CELL_W - 1));
      2, 3, 4: begin
        x = boundary_coord(grid_x);
        y = boundary_coord(grid_y);
        z = boundary_coord(grid_z);
        return CELL_W'(x + y * grid_x + z * grid_x * grid_y);
      end
      default: return CELL_W'($urandom_range(0, grid_x * grid_y * grid_z - 1));
    endcase
  endfunction

  function automatic int unsigned pick_axis();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 127);
      1, 2: return $urandom_range(1, 4);
      3: return $urandom_range(0, 1) ? 64 : 1;
      4: return $urandom_range(1, 64);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(13, 74);

    // Grid left at its reset size of one cell.
    send_request('0);
    send_request('1);

    // Largest grid, periodic: corners, faces and an interior cell.
    configure(64, 64, 64, 1);
    send_request('0);
    send_request('1);
    send_request(CELL_W'(63));
    send_request(CELL_W'(63 * 64));
    send_request(CELL_W'(63 * 4096));
    send_request(CELL_W'(1 + 64 + 4096));

    // Same grid with off-grid neighbours skipped.
    configure(64, 64, 64, 0);
    send_request('0);
    send_request('1);
    send_request(CELL_W'(1 + 64 + 4096));

    // Tiny grid where wrapping repeats cells, and an index past the grid.
    configure(2, 1, 3, 1);
    send_request('0);
    send_request(CELL_W'(5));
    send_request(CELL_W'(7));

    // Axis sizes of zero and above the limit are clamped.
    configure(0, 127, 1, 0);
    send_request('0);
    send_request(CELL_W'(63));
    send_request(CELL_W'(200));

    // Single cell without wrapping still gives cell 0.
    configure(1, 1, 1, 0);
    send_request(CELL_W'(5));

    configure(3, 2, 100, 1);
    send_request('0);
    send_request(CELL_W'(100));

    for (int phase = 0; phase < 11; phase++) begin
      if (phase == 4) set_idling(74, 13);
      if (phase == 8) set_idling(0, 0);
      configure(pick_axis(), pick_axis(), pick_axis(), $urandom_range(0, 1));
      repeat (30) send_request(pick_index());
    end

    drain();
    if (tracker.errors == 0)
      $display("neighbor_cell_enumerator_3d test passed");
    else
      $display("neighbor_cell_enumerator_3d test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nce_pkg.sv
sv/nce_div.sv
sv/nce_front.sv
sv/nce_queue.sv
sv/nce_back.sv
sv/neighbor_cell_enumerator_3d.sv
tb/neighbor_cell_enumerator_3d_test.sv
